// ===== src/two_stack_cursor_text_editor_defines.svh =====
// Assertion macros shared by the text editor RTL.
`ifndef TWO_STACK_CURSOR_TEXT_EDITOR_DEFINES_SVH
`define TWO_STACK_CURSOR_TEXT_EDITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSED_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tsed_pkg.sv =====
// Shared constants, types and state encoding of the text editor.
package tsed_pkg;

    localparam int TEXT_CAPACITY = 1024;
    localparam int WINDOW_CHARS  = 10;

    localparam int TOP_W  = $clog2(TEXT_CAPACITY + 1);
    localparam int ADDR_W = $clog2(TEXT_CAPACITY);
    localparam int WIN_W  = $clog2(WINDOW_CHARS + 1);
    localparam int DEL_W  = (TOP_W > 8) ? TOP_W : 8;

    localparam logic [TOP_W-1:0] CAP_TOP = TOP_W'(TEXT_CAPACITY);
    localparam logic [TOP_W-1:0] WIN_TOP = TOP_W'(WINDOW_CHARS);

    typedef enum logic [1:0] {
        FUNC_INSERT     = 2'd0,
        FUNC_DELETE     = 2'd1,
        FUNC_MOVE_LEFT  = 2'd2,
        FUNC_MOVE_RIGHT = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_MV_RD,
        S_MV_WR,
        S_WIN_SET,
        S_WIN_RD,
        S_WIN_EMIT
    } t_state;

    // Commands from the controller to the datapath; at most one per cycle.
    typedef struct packed {
        logic load_item;
        logic do_insert;
        logic do_delete;
        logic mv_read;
        logic mv_write;
        logic win_init;
        logic win_read;
        logic win_emit;
        logic emit_empty;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic mv_done;
        logic win_empty;
        logic win_last;
    } t_dp_sts;

endpackage

// ===== src/tsed_dp.sv =====
// Datapath: the two character stacks, their tops, the window walker and the result register.
module tsed_dp import tsed_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  logic [1:0] i_func,
    input  logic [7:0] i_char_in,
    input  logic [7:0] i_move_count,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [7:0] o_deleted_count,
    output logic [7:0] o_char_out,
    output logic       o_char_valid,
    output logic       o_overflow,
    output logic       o_last
);

    logic [7:0]       left_mem  [TEXT_CAPACITY];
    logic [7:0]       right_mem [TEXT_CAPACITY];

    logic [TOP_W-1:0] r_left_top;
    logic [TOP_W-1:0] r_right_top;
    logic [7:0]       r_char;
    logic [7:0]       r_cnt;
    logic             r_dir_left;
    logic [TOP_W-1:0] r_widx;
    logic [WIN_W-1:0] r_wrem;
    logic [7:0]       r_left_rd;
    logic [7:0]       r_right_rd;

    logic             r_out_valid;
    logic [7:0]       r_out_del;
    logic [7:0]       r_out_char;
    logic             r_out_cv;
    logic             r_out_ovf;
    logic             r_out_last;

    logic             w_full;
    logic [TOP_W:0]   w_sum;
    logic [DEL_W-1:0] w_k_ext;
    logic [DEL_W-1:0] w_left_ext;
    logic [DEL_W-1:0] w_del_n;
    logic [WIN_W-1:0] w_win_n;
    logic [TOP_W-1:0] w_left_m1;
    logic [TOP_W-1:0] w_right_m1;
    logic             w_left_we;
    logic             w_left_re;
    logic             w_right_we;
    logic             w_right_re;
    logic [ADDR_W-1:0] w_left_waddr;
    logic [ADDR_W-1:0] w_left_raddr;
    logic [7:0]       w_left_wdata;

    // Fill level and sizes of the current operation.
    always_comb begin
        w_sum      = {1'b0, r_left_top} + {1'b0, r_right_top};
        w_full     = (w_sum >= {1'b0, CAP_TOP}) || (r_left_top >= CAP_TOP);
        w_k_ext    = DEL_W'(r_cnt);
        w_left_ext = DEL_W'(r_left_top);
        w_del_n    = (w_k_ext < w_left_ext) ? w_k_ext : w_left_ext;
        w_win_n    = (r_left_top < WIN_TOP) ? r_left_top[WIN_W-1:0] : WIN_W'(WINDOW_CHARS);
        w_left_m1  = r_left_top - TOP_W'(1);
        w_right_m1 = r_right_top - TOP_W'(1);
    end

    // Status toward the controller.
    always_comb begin
        o_sts.out_free  = !r_out_valid || !i_out_stall;
        o_sts.win_empty = (r_left_top == '0);
        o_sts.win_last  = (r_wrem == '0);
        if (r_dir_left) begin
            o_sts.mv_done = (r_cnt == '0) || (r_left_top == '0) || (r_right_top >= CAP_TOP);
        end else begin
            o_sts.mv_done = (r_cnt == '0) || (r_right_top == '0) || (r_left_top >= CAP_TOP);
        end
    end

    // Memory port controls: one write and one read per stack per cycle.
    always_comb begin
        w_left_we    = (i_cmd.do_insert && !w_full) || (i_cmd.mv_write && !r_dir_left);
        w_left_waddr = r_left_top[ADDR_W-1:0];
        w_left_wdata = i_cmd.do_insert ? r_char : r_right_rd;
        w_left_re    = i_cmd.win_read || (i_cmd.mv_read && r_dir_left);
        w_left_raddr = i_cmd.win_read ? r_widx[ADDR_W-1:0] : w_left_m1[ADDR_W-1:0];
        w_right_we   = i_cmd.mv_write && r_dir_left;
        w_right_re   = i_cmd.mv_read && !r_dir_left;
    end

    // Left stack storage with registered read.
    always_ff @(posedge i_clk) begin
        if (w_left_we) begin
            left_mem[w_left_waddr] <= w_left_wdata;
        end
        if (w_left_re) begin
            r_left_rd <= left_mem[w_left_raddr];
        end
    end

    // Right stack storage with registered read.
    always_ff @(posedge i_clk) begin
        if (w_right_we) begin
            right_mem[r_right_top[ADDR_W-1:0]] <= r_left_rd;
        end
        if (w_right_re) begin
            r_right_rd <= right_mem[w_right_m1[ADDR_W-1:0]];
        end
    end

    // Stack tops follow pushes, pops and shifts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_top  <= '0;
            r_right_top <= '0;
        end else begin
            if (i_cmd.do_insert && !w_full) begin
                r_left_top <= r_left_top + TOP_W'(1);
            end
            if (i_cmd.do_delete) begin
                r_left_top <= r_left_top - w_del_n[TOP_W-1:0];
            end
            if (i_cmd.mv_read) begin
                if (r_dir_left) begin
                    r_left_top <= w_left_m1;
                end else begin
                    r_right_top <= w_right_m1;
                end
            end
            if (i_cmd.mv_write) begin
                if (r_dir_left) begin
                    r_right_top <= r_right_top + TOP_W'(1);
                end else begin
                    r_left_top <= r_left_top + TOP_W'(1);
                end
            end
        end
    end

    // Item latch, move counter and window walker.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_char     <= i_char_in;
            r_cnt      <= i_move_count;
            r_dir_left <= (t_func'(i_func) == FUNC_MOVE_LEFT);
        end
        if (i_cmd.mv_read) begin
            r_cnt <= r_cnt - 8'd1;
        end
        if (i_cmd.win_init) begin
            r_widx <= r_left_top - TOP_W'(w_win_n);
            r_wrem <= w_win_n;
        end
        if (i_cmd.win_read) begin
            r_widx <= r_widx + TOP_W'(1);
            r_wrem <= r_wrem - WIN_W'(1);
        end
    end

    // Result register: loaded by an emit command, cleared when its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.do_insert || i_cmd.do_delete || i_cmd.win_emit || i_cmd.emit_empty) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_insert || i_cmd.do_delete || i_cmd.win_emit || i_cmd.emit_empty) begin
            r_out_del  <= i_cmd.do_delete ? w_del_n[7:0] : 8'd0;
            r_out_char <= i_cmd.win_emit ? r_left_rd : 8'd0;
            r_out_cv   <= i_cmd.win_emit;
            r_out_ovf  <= i_cmd.do_insert && w_full;
            r_out_last <= i_cmd.win_emit ? (r_wrem == '0) : 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_deleted_count = r_out_del;
    assign o_char_out      = r_out_char;
    assign o_char_valid    = r_out_cv;
    assign o_overflow      = r_out_ovf;
    assign o_last          = r_out_last;

endmodule

// ===== src/tsed_ctrl.sv =====
// Controller: state machine that sequences each item through the datapath.
module tsed_ctrl import tsed_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_stall,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE) || !i_sts.out_free;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    o_cmd.load_item = 1'b1;
                    case (t_func'(i_func))
                        FUNC_INSERT: n_state = S_INS;
                        FUNC_DELETE: n_state = S_DEL;
                        default:     n_state = S_MV_RD;
                    endcase
                end
            end
            S_INS: begin
                if (i_sts.out_free) begin
                    o_cmd.do_insert = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DEL: begin
                if (i_sts.out_free) begin
                    o_cmd.do_delete = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_MV_RD: begin
                if (i_sts.mv_done) begin
                    n_state = S_WIN_SET;
                end else begin
                    o_cmd.mv_read = 1'b1;
                    n_state       = S_MV_WR;
                end
            end
            S_MV_WR: begin
                o_cmd.mv_write = 1'b1;
                n_state        = S_MV_RD;
            end
            S_WIN_SET: begin
                if (i_sts.win_empty) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_empty = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.win_init = 1'b1;
                    n_state        = S_WIN_RD;
                end
            end
            S_WIN_RD: begin
                o_cmd.win_read = 1'b1;
                n_state        = S_WIN_EMIT;
            end
            S_WIN_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.win_emit = 1'b1;
                    n_state        = i_sts.win_last ? S_IDLE : S_WIN_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/two_stack_cursor_text_editor.sv =====
// Top level of the two-stack cursor text editor.
// Input channel: i_in_valid / o_in_stall carry i_func, i_char_in and i_move_count.
// Output channel: o_out_valid / i_out_stall carry one result per transfer.
// Insert and delete give one result, loaded by S_INS or S_DEL once the result
// register is free. A move shifts characters between the stacks, each by a
// read of the source stack in S_MV_RD, then a write of the other in S_MV_WR,
// then reads the window of up to ten characters left of the cursor, each by a
// read in S_WIN_RD, then an emit in S_WIN_EMIT.
// One item is in work at a time; the next input transfer is taken once the
// state machine is idle and the result register is empty or draining.
// A stalled receiver holds the result register and pauses the item's sequence.
// Reset clears both stack tops and the result register; the stacks hold no
// data until written and need no clearing pass.
`include "two_stack_cursor_text_editor_defines.svh"

module two_stack_cursor_text_editor import tsed_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_char_in,
    input  logic [7:0] i_move_count,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_deleted_count,
    output logic [7:0] o_char_out,
    output logic       o_char_valid,
    output logic       o_overflow,
    output logic       o_last
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    tsed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Stacks and result register.
    tsed_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_func          (i_func),
        .i_char_in       (i_char_in),
        .i_move_count    (i_move_count),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_deleted_count (o_deleted_count),
        .o_char_out      (o_char_out),
        .o_char_valid    (o_char_valid),
        .o_overflow      (o_overflow),
        .o_last          (o_last)
    );

    // The controller never issues two commands in one cycle.
    `TSED_ASSERT_NOW(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd), "two datapath commands at once")

    // A result is loaded only when the result register is free.
    `TSED_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, w_cmd.do_insert || w_cmd.do_delete || w_cmd.win_emit || w_cmd.emit_empty, w_sts.out_free, "result register overwritten")

    // After an input transfer the block is busy with that item.
    `TSED_ASSERT_NXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken while an item is in work")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the two-stack cursor text editor.
module testbench import tsed_pkg::*;;

    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned NUM_DIRECTED  = 25;
    localparam int unsigned MIXED_FIRST   = 160;
    localparam int unsigned MIXED_SECOND  = 125;
    localparam int unsigned SETTLE_CYCLES = 40;

    // One result of the editor, in port order.
    typedef struct packed {
        logic [7:0] deleted_count;
        logic [7:0] char_out;
        logic       char_valid;
        logic       overflow;
        logic       last;
    } edit_result_t;

    // One row of the directed table; typed rows carry their expected result.
    typedef struct packed {
        t_func        func;
        logic [7:0]   ch;
        logic [7:0]   count;
        logic         typed;
        edit_result_t res;
    } directed_row_t;

    // Accepted insert and empty window both give a bare final result.
    localparam edit_result_t RES_PLAIN = '{8'd0, 8'h00, 1'b0, 1'b0, 1'b1};

    localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
        '{FUNC_MOVE_LEFT,  8'h00, 8'd5,   1'b1, RES_PLAIN},
        '{FUNC_MOVE_RIGHT, 8'hFF, 8'd255, 1'b1, RES_PLAIN},
        '{FUNC_DELETE,     8'h00, 8'd255, 1'b1, '{8'd0, 8'h00, 1'b0, 1'b0, 1'b1}},
        '{FUNC_INSERT,     8'h00, 8'd0,   1'b1, RES_PLAIN},
        '{FUNC_INSERT,     8'hFF, 8'd255, 1'b1, RES_PLAIN},
        '{FUNC_INSERT,     8'h80, 8'd1,   1'b1, RES_PLAIN},
        '{FUNC_INSERT,     8'h01, 8'd128, 1'b1, RES_PLAIN},
        '{FUNC_INSERT,     8'hFE, 8'd0,   1'b1, RES_PLAIN},
        '{FUNC_INSERT,     8'h55, 8'd0,   1'b1, RES_PLAIN},
        '{FUNC_INSERT,     8'hAA, 8'd0,   1'b1, RES_PLAIN},
        '{FUNC_INSERT,     8'h0F, 8'd0,   1'b1, RES_PLAIN},
        '{FUNC_INSERT,     8'hF0, 8'd0,   1'b1, RES_PLAIN},
        '{FUNC_INSERT,     8'h33, 8'd0,   1'b1, RES_PLAIN},
        '{FUNC_INSERT,     8'hCC, 8'd0,   1'b1, RES_PLAIN},
        '{FUNC_MOVE_LEFT,  8'h00, 8'd0,   1'b0, RES_PLAIN},
        '{FUNC_MOVE_LEFT,  8'h00, 8'd3,   1'b0, RES_PLAIN},
        '{FUNC_MOVE_RIGHT, 8'h00, 8'd255, 1'b0, RES_PLAIN},
        '{FUNC_MOVE_LEFT,  8'h00, 8'd255, 1'b1, RES_PLAIN},
        '{FUNC_MOVE_RIGHT, 8'h00, 8'd1,   1'b0, RES_PLAIN},
        '{FUNC_DELETE,     8'h00, 8'd0,   1'b1, '{8'd0, 8'h00, 1'b0, 1'b0, 1'b1}},
        '{FUNC_DELETE,     8'h00, 8'd1,   1'b1, '{8'd1, 8'h00, 1'b0, 1'b0, 1'b1}},
        '{FUNC_MOVE_RIGHT, 8'h00, 8'd4,   1'b0, RES_PLAIN},
        '{FUNC_DELETE,     8'h00, 8'd255, 1'b1, '{8'd4, 8'h00, 1'b0, 1'b0, 1'b1}},
        '{FUNC_MOVE_RIGHT, 8'h00, 8'd255, 1'b0, RES_PLAIN},
        '{FUNC_DELETE,     8'h00, 8'd200, 1'b1, '{8'd6, 8'h00, 1'b0, 1'b0, 1'b1}}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       edit_valid;
    logic       edit_stall;
    t_func      edit_func;
    logic [7:0] edit_char;
    logic [7:0] edit_count;
    logic       res_valid;
    logic       res_stall;
    logic [7:0] res_deleted_count;
    logic [7:0] res_char_out;
    logic       res_char_valid;
    logic       res_overflow;
    logic       res_last;

    // Predicted text: two stacks with their fill levels.
    logic [7:0]   left_text  [TEXT_CAPACITY];
    logic [7:0]   right_text [TEXT_CAPACITY];
    int unsigned  left_len;
    int unsigned  right_len;
    int unsigned  fullest_text;

    edit_result_t edit_run [$];
    edit_result_t expected_results [$];

    int unsigned  cycle_count;
    int unsigned  error_count;
    int unsigned  edits_sent;
    int unsigned  results_seen;
    int unsigned  dropped_inserts;
    int unsigned  burst_left;
    logic         hold_done;

    two_stack_cursor_text_editor uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (edit_valid),
        .o_in_stall      (edit_stall),
        .i_func          (edit_func),
        .i_char_in       (edit_char),
        .i_move_count    (edit_count),
        .o_out_valid     (res_valid),
        .i_out_stall     (res_stall),
        .o_deleted_count (res_deleted_count),
        .o_char_out      (res_char_out),
        .o_char_valid    (res_char_valid),
        .o_overflow      (res_overflow),
        .o_last          (res_last)
    );

    // Clock with a period of 8.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Adds one result to the run of the edit being predicted.
    function automatic void add_to_run(edit_result_t r);
        edit_run = {edit_run, r};
    endfunction

    // Adds one result to the tail of the expected results.
    function automatic void add_expected(edit_result_t r);
        expected_results = {expected_results, r};
    endfunction

    // Applies one edit to the predicted text and leaves its results in edit_run.
    function automatic void predict_edit(t_func f, logic [7:0] ch, logic [7:0] k);
        int unsigned  shifted;
        int unsigned  win;
        edit_result_t r;
        edit_run.delete();
        r = RES_PLAIN;
        case (f)
            FUNC_INSERT: begin
                if (left_len + right_len >= TEXT_CAPACITY) begin
                    r.overflow = 1'b1;
                end else begin
                    left_text[left_len] = ch;
                    left_len++;
                    if (left_len + right_len > fullest_text) begin
                        fullest_text = left_len + right_len;
                    end
                end
                add_to_run(r);
            end
            FUNC_DELETE: begin
                shifted = (k < left_len) ? k : left_len;
                left_len -= shifted;
                r.deleted_count = shifted[7:0];
                add_to_run(r);
            end
            default: begin
                // The shift stops early when the source stack runs empty or the other is full.
                shifted = 0;
                if (f == FUNC_MOVE_LEFT) begin
                    while (shifted < k && left_len > 0 && right_len < TEXT_CAPACITY) begin
                        left_len--;
                        right_text[right_len] = left_text[left_len];
                        right_len++;
                        shifted++;
                    end
                end else begin
                    while (shifted < k && right_len > 0 && left_len < TEXT_CAPACITY) begin
                        right_len--;
                        left_text[left_len] = right_text[right_len];
                        left_len++;
                        shifted++;
                    end
                end
                // Window of the last characters left of the cursor, oldest first.
                win = (left_len < WINDOW_CHARS) ? left_len : WINDOW_CHARS;
                if (win == 0) begin
                    add_to_run(r);
                end else begin
                    for (int unsigned i = 0; i < win; i++) begin
                        r.char_out   = left_text[left_len - win + i];
                        r.char_valid = 1'b1;
                        r.last       = (i + 1 == win);
                        add_to_run(r);
                    end
                end
            end
        endcase
    endfunction

    // Gap after a transfer: bursts of random length, random idle stretches between.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge clk);
                edit_valid <= 1'b0;
            end
            burst_left = $urandom_range(0, 11);
        end
    endtask

    // Offers one edit, waits for its transfer, then records what it should produce.
    task automatic offer_edit(input t_func f, input logic [7:0] ch, input logic [7:0] k,
                              input logic typed, input edit_result_t typed_res);
        @(negedge clk);
        edit_valid <= 1'b1;
        edit_func  <= f;
        edit_char  <= ch;
        edit_count <= k;
        @(posedge clk);
        while (edit_stall) @(posedge clk);
        predict_edit(f, ch, k);
        if (typed) begin
            add_expected(typed_res);
        end else begin
            foreach (edit_run[i]) add_expected(edit_run[i]);
        end
        edits_sent++;
        pace_sender();
    endtask

    // A mixed edit: mostly short counts, sometimes the full range.
    task automatic random_edit();
        int unsigned sel;
        logic [7:0]  k;
        t_func       f;
        sel = $urandom_range(0, 99);
        k = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 15));
        if (sel < 45) begin
            f = FUNC_INSERT;
        end else if (sel < 60) begin
            f = FUNC_DELETE;
        end else if (sel < 80) begin
            f = FUNC_MOVE_LEFT;
        end else begin
            f = FUNC_MOVE_RIGHT;
        end
        offer_edit(f, 8'($urandom_range(0, 255)), k, 1'b0, RES_PLAIN);
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        edit_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Compare each result transfer with the oldest prediction.
    always @(posedge clk) begin
        edit_result_t got;
        edit_result_t want;
        if (rst_n && res_valid && !res_stall) begin
            got = '{res_deleted_count, res_char_out, res_char_valid, res_overflow, res_last};
            results_seen++;
            if (got.overflow === 1'b1) dropped_inserts++;
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                want = expected_results.pop_front();
                check_field("deleted_count", want.deleted_count, got.deleted_count);
                check_field("char_out", want.char_out, got.char_out);
                check_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
                check_field("overflow", 8'(want.overflow), 8'(got.overflow));
                check_field("last", 8'(want.last), 8'(got.last));
            end
        end
    end

    // Receiver stalls in spans of changing pattern, with one long hold early on.
    initial begin
        int unsigned mode;
        int unsigned span;
        res_stall = 1'b0;
        hold_done = 1'b0;
        forever begin
            if (!hold_done && results_seen >= 60) begin
                hold_done = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge clk);
                    res_stall <= 1'b1;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 64);
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    0:       res_stall <= 1'b0;
                    1:       res_stall <= ($urandom_range(0, 99) < 40);
                    2:       res_stall <= ~res_stall;
                    default: res_stall <= ($urandom_range(0, 99) < 80);
                endcase
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run timed out after %0d cycles", $time, cycle_count);
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus: directed table, mixed edits, cursor at the ends, mixed edits again.
    initial begin
        edit_valid      = 1'b0;
        edit_func       = FUNC_INSERT;
        edit_char       = 8'h00;
        edit_count      = 8'd0;
        rst_n           = 1'b0;
        left_len        = 0;
        right_len       = 0;
        fullest_text    = 0;
        error_count     = 0;
        edits_sent      = 0;
        results_seen    = 0;
        dropped_inserts = 0;
        burst_left      = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int unsigned i = 0; i < NUM_DIRECTED; i++) begin
            offer_edit(DIRECTED[i].func, DIRECTED[i].ch, DIRECTED[i].count,
                       DIRECTED[i].typed, DIRECTED[i].res);
        end

        for (int unsigned i = 0; i < MIXED_FIRST; i++) random_edit();
        wait_for_results();

        // Inserts, cursor at both ends of the text, maximal deletes.
        repeat (3) offer_edit(FUNC_INSERT, 8'($urandom_range(0, 255)), 8'd0, 1'b0, RES_PLAIN);
        repeat (5) offer_edit(FUNC_MOVE_LEFT, 8'h00, 8'd255, 1'b0, RES_PLAIN);
        offer_edit(FUNC_MOVE_LEFT, 8'h00, 8'd1, 1'b0, RES_PLAIN);
        offer_edit(FUNC_INSERT, 8'h5A, 8'd0, 1'b0, RES_PLAIN);
        repeat (5) offer_edit(FUNC_MOVE_RIGHT, 8'h00, 8'd255, 1'b0, RES_PLAIN);
        offer_edit(FUNC_MOVE_RIGHT, 8'h00, 8'd9, 1'b0, RES_PLAIN);
        offer_edit(FUNC_INSERT, 8'hA5, 8'd0, 1'b0, RES_PLAIN);
        repeat (3) offer_edit(FUNC_DELETE, 8'h00, 8'd255, 1'b0, RES_PLAIN);

        for (int unsigned i = 0; i < MIXED_SECOND; i++) random_edit();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (expected_results.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        end
        $display("Covered %0d edits (directed, mixed, cursor at both ends), %0d results checked.",
                 edits_sent, results_seen);
        $display("Fullest text %0d of %0d characters, %0d inserts dropped when full.",
                 fullest_text, TEXT_CAPACITY, dropped_inserts);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
